// File: rtl/qrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

    localparam int COEF_BITS      = 16;
    localparam int ROOT_FRAC_BITS = 16;
    localparam int ROOT_W         = 32;
    localparam int KIND_W         = 3;

    localparam logic [KIND_W-1:0] KIND_ALL    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LINEAR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TWO    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NEG    = 3'd5;

    localparam logic [ROOT_W-1:0] ROOT_MAX = 32'h7FFF_FFFF;
    localparam logic [ROOT_W-1:0] ROOT_MIN = 32'h8000_0000;

endpackage
`default_nettype wire

// File: rtl/qrs_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface qrs_coef_if #(
    parameter int COEF_BITS = qrs_pkg::COEF_BITS
);
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] coef_a;
    logic signed [COEF_BITS-1:0] coef_b;
    logic signed [COEF_BITS-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_root_if;
    logic                                valid;
    logic                                ready;
    logic [qrs_pkg::KIND_W-1:0]          solution_kind;
    logic signed [qrs_pkg::ROOT_W-1:0]   root_plus;
    logic signed [qrs_pkg::ROOT_W-1:0]   root_minus;
    logic                                overflow;

    modport source (output valid, output solution_kind, output root_plus,
                    output root_minus, output overflow, input ready);
    modport sink   (input valid, input solution_kind, input root_plus,
                    input root_minus, input overflow, output ready);
endinterface
`default_nettype wire

// File: rtl/qrs_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One digit of a restoring square root: brings in two radicand bits,
// decides one root bit.
module qrs_sqrt_cell #(
    parameter int SB     = 33,
    parameter int K      = 0,
    parameter int SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [2*SB-1:0]   i_x,
    input  wire logic [SB+1:0]     i_rem,
    input  wire logic [SB-1:0]     i_root,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [2*SB-1:0]        o_x,
    output logic [SB+1:0]          o_rem,
    output logic [SB-1:0]          o_root,
    output logic [SIDE_W-1:0]      o_side
);
    logic [SB+1:0] w_shift;
    logic [SB+1:0] w_trial;
    logic          w_take;
    logic [SB+1:0] n_rem;
    logic [SB-1:0] n_root;

    always_comb begin
        w_shift = {i_rem[SB-1:0], i_x[2*K+1], i_x[2*K]};
        w_trial = {i_root, 2'b01};
        w_take  = (w_shift >= w_trial);
        n_rem   = w_take ? (w_shift - w_trial) : w_shift;
        n_root  = {i_root[SB-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= i_x;
            o_rem  <= n_rem;
            o_root <= n_root;
            o_side <= i_side;
        end
    end
endmodule
`default_nettype wire

// File: rtl/qrs_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One step of a restoring divider: shift in dividend bit IDX, subtract if it fits.
module qrs_div_cell #(
    parameter int NB     = 34,
    parameter int DNB    = 17,
    parameter int IDX    = 0,
    parameter int SIDE_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [NB-1:0]     i_num,
    input  wire logic [DNB-1:0]    i_den,
    input  wire logic [DNB-1:0]    i_rem,
    input  wire logic [NB-1:0]     i_quo,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [NB-1:0]          o_num,
    output logic [DNB-1:0]         o_den,
    output logic [DNB-1:0]         o_rem,
    output logic [NB-1:0]          o_quo,
    output logic [SIDE_W-1:0]      o_side
);
    logic [DNB:0]   w_trial;
    logic [DNB:0]   w_diff;
    logic           w_take;
    logic [DNB-1:0] n_rem;
    logic [NB-1:0]  n_quo;

    always_comb begin
        w_trial  = {i_rem, i_num[IDX]};
        w_diff   = w_trial - {1'b0, i_den};
        w_take   = (w_trial >= {1'b0, i_den});
        n_rem    = w_take ? w_diff[DNB-1:0] : w_trial[DNB-1:0];
        n_quo    = i_quo;
        n_quo[IDX] = w_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num  <= i_num;
            o_den  <= i_den;
            o_rem  <= n_rem;
            o_quo  <= n_quo;
            o_side <= i_side;
        end
    end
endmodule
`default_nettype wire

// File: rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// Real roots of a*x^2 + b*x + c = 0 for signed fixed-point coefficients, roots in signed
// fixed point with ROOT_FRAC_BITS fraction bits, rounded to nearest (ties away from zero)
// and saturated with an overflow flag. One coefficient set is accepted per cycle while the
// output is not stalled. Each result passes the input, product and discriminant registers,
// the square root chain, one cell per root bit, a numerator register, the two divider
// chains, one cell per quotient bit, and the output register. The whole pipeline holds
// while a finished result is not taken.
module quadratic_root_solver #(
    parameter int COEF_BITS      = qrs_pkg::COEF_BITS,
    parameter int ROOT_FRAC_BITS = qrs_pkg::ROOT_FRAC_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    qrs_coef_if.sink    i_coef,
    qrs_root_if.source  o_root
);
    localparam int W     = COEF_BITS;
    localparam int R     = ROOT_FRAC_BITS;
    localparam int KW    = qrs_pkg::KIND_W;
    localparam int OW    = qrs_pkg::ROOT_W;
    localparam int DBITS = 2 * W + 1;
    localparam int SB    = W + R + 1;
    localparam int XW    = 2 * SB;
    localparam int NB    = W + R + 2;
    localparam int SNB   = NB + 1;
    localparam int DNB   = W + 1;
    localparam int SQS   = KW + 3 * W;
    localparam int PS    = KW + 2;
    localparam int QX    = (NB > OW + 1) ? NB : OW + 1;

    logic w_en;
    assign w_en         = !o_root.valid || o_root.ready;
    assign i_coef.ready = w_en;

    // input register
    logic                r_v1;
    logic signed [W-1:0] r_a1, r_b1, r_c1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_coef.valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a1 <= i_coef.coef_a;
            r_b1 <= i_coef.coef_b;
            r_c1 <= i_coef.coef_c;
        end
    end

    // products of magnitudes
    logic [W-1:0] w_am1, w_bm1, w_cm1;
    assign w_am1 = r_a1[W-1] ? W'(-r_a1) : W'(r_a1);
    assign w_bm1 = r_b1[W-1] ? W'(-r_b1) : W'(r_b1);
    assign w_cm1 = r_c1[W-1] ? W'(-r_c1) : W'(r_c1);

    logic                r_v2;
    logic [2*W-1:0]      r_b2, r_ac2;
    logic signed [W-1:0] r_a2, r_b2c, r_c2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b2  <= w_bm1 * w_bm1;
            r_ac2 <= w_am1 * w_cm1;
            r_a2  <= r_a1;
            r_b2c <= r_b1;
            r_c2  <= r_c1;
        end
    end

    // discriminant and kind
    logic [2*W+1:0] w_p4, w_b2x, w_sum, w_dif;
    logic           w_acneg, w_ge;
    logic [KW-1:0]  w_kind3;
    logic [DBITS-1:0] w_d3;
    always_comb begin
        w_p4    = {r_ac2, 2'b00};
        w_b2x   = {2'b00, r_b2};
        w_sum   = w_b2x + w_p4;
        w_dif   = w_b2x - w_p4;
        w_acneg = (r_a2[W-1] != r_c2[W-1]) && (r_ac2 != '0);
        w_ge    = (w_b2x >= w_p4);
        w_d3    = w_acneg ? w_sum[DBITS-1:0] : w_dif[DBITS-1:0];
        if (r_a2 == '0) begin
            if (r_b2c == '0) begin
                w_kind3 = (r_c2 == '0) ? qrs_pkg::KIND_ALL : qrs_pkg::KIND_NONE;
            end else begin
                w_kind3 = qrs_pkg::KIND_LINEAR;
            end
        end else if (!w_acneg && !w_ge) begin
            w_kind3 = qrs_pkg::KIND_NEG;
        end else if (w_d3 == '0) begin
            w_kind3 = qrs_pkg::KIND_DOUBLE;
        end else begin
            w_kind3 = qrs_pkg::KIND_TWO;
        end
    end

    logic             r_v3;
    logic [DBITS-1:0] r_d3;
    logic [SQS-1:0]   r_side3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d3    <= w_d3;
            r_side3 <= {w_kind3, r_a2, r_b2c, r_c2};
        end
    end

    // square root chain
    logic            sq_v    [0:SB];
    logic [XW-1:0]   sq_x    [0:SB];
    logic [SB+1:0]   sq_rem  [0:SB];
    logic [SB-1:0]   sq_root [0:SB];
    logic [SQS-1:0]  sq_side [0:SB];

    assign sq_v[0]    = r_v3;
    assign sq_x[0]    = XW'({r_d3, {(2*R){1'b0}}});
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = r_side3;

    for (genvar i = 0; i < SB; i++) begin : g_sqrt
        qrs_sqrt_cell #(.SB(SB), .K(SB - 1 - i), .SIDE_W(SQS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (sq_v[i]),
            .i_x     (sq_x[i]),
            .i_rem   (sq_rem[i]),
            .i_root  (sq_root[i]),
            .i_side  (sq_side[i]),
            .o_valid (sq_v[i+1]),
            .o_x     (sq_x[i+1]),
            .o_rem   (sq_rem[i+1]),
            .o_root  (sq_root[i+1]),
            .o_side  (sq_side[i+1])
        );
    end

    // numerators and denominator
    logic [KW-1:0]         w_k4;
    logic signed [W-1:0]   w_a4, w_b4, w_c4;
    logic [W-1:0]          w_am4, w_bm4;
    logic signed [SNB-1:0] w_nb4, w_nc4, w_s4, w_np4, w_nm4, w_pa4, w_ma4;
    logic [DNB-1:0]        w_den4;
    logic                  w_dneg4;
    always_comb begin
        {w_k4, w_a4, w_b4, w_c4} = sq_side[SB];
        w_am4 = w_a4[W-1] ? W'(-w_a4) : W'(w_a4);
        w_bm4 = w_b4[W-1] ? W'(-w_b4) : W'(w_b4);
        w_nb4 = -(SNB'(w_b4) <<< R);
        w_nc4 = -(SNB'(w_c4) <<< R);
        w_s4  = $signed(SNB'(sq_root[SB]));
        unique case (w_k4)
            qrs_pkg::KIND_TWO: begin
                w_np4 = w_nb4 + w_s4;
                w_nm4 = w_nb4 - w_s4;
                w_den4 = {w_am4, 1'b0};
                w_dneg4 = w_a4[W-1];
            end
            qrs_pkg::KIND_DOUBLE: begin
                w_np4 = w_nb4;
                w_nm4 = '0;
                w_den4 = {w_am4, 1'b0};
                w_dneg4 = w_a4[W-1];
            end
            qrs_pkg::KIND_LINEAR: begin
                w_np4 = w_nc4;
                w_nm4 = '0;
                w_den4 = {1'b0, w_bm4};
                w_dneg4 = w_b4[W-1];
            end
            default: begin
                w_np4 = '0;
                w_nm4 = '0;
                w_den4 = DNB'(1);
                w_dneg4 = 1'b0;
            end
        endcase
        w_pa4 = w_np4[SNB-1] ? -w_np4 : w_np4;
        w_ma4 = w_nm4[SNB-1] ? -w_nm4 : w_nm4;
    end

    logic           r_v4;
    logic [NB-1:0]  r_unp4, r_unm4;
    logic [DNB-1:0] r_den4;
    logic [PS-1:0]  r_side4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= sq_v[SB];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // add half the divisor to round to nearest
            r_unp4  <= w_pa4[NB-1:0] + NB'(w_den4 >> 1);
            r_unm4  <= w_ma4[NB-1:0] + NB'(w_den4 >> 1);
            r_den4  <= w_den4;
            r_side4 <= {w_k4, w_np4[SNB-1] ^ w_dneg4, w_nm4[SNB-1] ^ w_dneg4};
        end
    end

    // two divider chains
    logic           dp_v    [0:NB];
    logic [NB-1:0]  dp_num  [0:NB];
    logic [DNB-1:0] dp_den  [0:NB];
    logic [DNB-1:0] dp_rem  [0:NB];
    logic [NB-1:0]  dp_quo  [0:NB];
    logic [PS-1:0]  dp_side [0:NB];
    logic           dm_v    [0:NB];
    logic [NB-1:0]  dm_num  [0:NB];
    logic [DNB-1:0] dm_den  [0:NB];
    logic [DNB-1:0] dm_rem  [0:NB];
    logic [NB-1:0]  dm_quo  [0:NB];
    logic [0:0]     dm_side [0:NB];

    assign dp_v[0]    = r_v4;
    assign dp_num[0]  = r_unp4;
    assign dp_den[0]  = r_den4;
    assign dp_rem[0]  = '0;
    assign dp_quo[0]  = '0;
    assign dp_side[0] = r_side4;
    assign dm_v[0]    = r_v4;
    assign dm_num[0]  = r_unm4;
    assign dm_den[0]  = r_den4;
    assign dm_rem[0]  = '0;
    assign dm_quo[0]  = '0;
    assign dm_side[0] = r_side4[0];

    for (genvar i = 0; i < NB; i++) begin : g_div
        qrs_div_cell #(.NB(NB), .DNB(DNB), .IDX(NB - 1 - i), .SIDE_W(PS)) u_plus (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (dp_v[i]),
            .i_num   (dp_num[i]),
            .i_den   (dp_den[i]),
            .i_rem   (dp_rem[i]),
            .i_quo   (dp_quo[i]),
            .i_side  (dp_side[i]),
            .o_valid (dp_v[i+1]),
            .o_num   (dp_num[i+1]),
            .o_den   (dp_den[i+1]),
            .o_rem   (dp_rem[i+1]),
            .o_quo   (dp_quo[i+1]),
            .o_side  (dp_side[i+1])
        );
        qrs_div_cell #(.NB(NB), .DNB(DNB), .IDX(NB - 1 - i), .SIDE_W(1)) u_minus (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (dm_v[i]),
            .i_num   (dm_num[i]),
            .i_den   (dm_den[i]),
            .i_rem   (dm_rem[i]),
            .i_quo   (dm_quo[i]),
            .i_side  (dm_side[i]),
            .o_valid (dm_v[i+1]),
            .o_num   (dm_num[i+1]),
            .o_den   (dm_den[i+1]),
            .o_rem   (dm_rem[i+1]),
            .o_quo   (dm_quo[i+1]),
            .o_side  (dm_side[i+1])
        );
    end

    // sign, saturate, mask unused fields
    logic [KW-1:0] w_k5;
    logic          w_negp, w_negm, w_ovp, w_ovm;
    logic [QX-1:0] w_qp, w_qm;
    logic [OW-1:0] w_rp, w_rm, n_rp, n_rm;
    logic          n_ovf;
    always_comb begin
        w_k5   = dp_side[NB][PS-1:2];
        w_negp = dp_side[NB][1];
        w_negm = dm_side[NB][0];
        w_qp   = QX'(dp_quo[NB]);
        w_qm   = QX'(dm_quo[NB]);
        w_ovp  = w_negp ? (w_qp > QX'({1'b0, qrs_pkg::ROOT_MIN}))
                        : (w_qp > QX'({1'b0, qrs_pkg::ROOT_MAX}));
        w_ovm  = w_negm ? (w_qm > QX'({1'b0, qrs_pkg::ROOT_MIN}))
                        : (w_qm > QX'({1'b0, qrs_pkg::ROOT_MAX}));
        if (w_ovp) begin
            w_rp = w_negp ? qrs_pkg::ROOT_MIN : qrs_pkg::ROOT_MAX;
        end else begin
            w_rp = w_negp ? OW'(-w_qp) : OW'(w_qp);
        end
        if (w_ovm) begin
            w_rm = w_negm ? qrs_pkg::ROOT_MIN : qrs_pkg::ROOT_MAX;
        end else begin
            w_rm = w_negm ? OW'(-w_qm) : OW'(w_qm);
        end
        unique case (w_k5)
            qrs_pkg::KIND_TWO: begin
                n_rp  = w_rp;
                n_rm  = w_rm;
                n_ovf = w_ovp || w_ovm;
            end
            qrs_pkg::KIND_DOUBLE, qrs_pkg::KIND_LINEAR: begin
                n_rp  = w_rp;
                n_rm  = '0;
                n_ovf = w_ovp;
            end
            default: begin
                n_rp  = '0;
                n_rm  = '0;
                n_ovf = 1'b0;
            end
        endcase
    end

    logic          r_ov;
    logic [KW-1:0] r_kind;
    logic [OW-1:0] r_rp, r_rm;
    logic          r_ovf;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= dp_v[NB] && dm_v[NB];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kind <= w_k5;
            r_rp   <= n_rp;
            r_rm   <= n_rm;
            r_ovf  <= n_ovf;
        end
    end

    assign o_root.valid         = r_ov;
    assign o_root.solution_kind = r_kind;
    assign o_root.root_plus     = $signed(r_rp);
    assign o_root.root_minus    = $signed(r_rm);
    assign o_root.overflow      = r_ovf;
endmodule
`default_nettype wire

// File: rtl/qrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module qrs_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [qrs_pkg::KIND_W-1:0]   i_kind,
    input wire logic [qrs_pkg::ROOT_W-1:0]   i_rp,
    input wire logic [qrs_pkg::ROOT_W-1:0]   i_rm,
    input wire logic                         i_ovf
);
    // hold a stalled result transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_kind) && $stable(i_rp) && $stable(i_rm) && $stable(i_ovf))
        else $error("stalled result changed");

    a_no_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == qrs_pkg::KIND_ALL || i_kind == qrs_pkg::KIND_NONE ||
                        i_kind == qrs_pkg::KIND_NEG)
            |-> i_rp == '0 && i_rm == '0 && !i_ovf)
        else $error("roots present for a rootless kind");

    a_minus_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != qrs_pkg::KIND_TWO |-> i_rm == '0)
        else $error("second root present without two roots");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ovf |->
            i_rp == qrs_pkg::ROOT_MAX || i_rp == qrs_pkg::ROOT_MIN ||
            i_rm == qrs_pkg::ROOT_MAX || i_rm == qrs_pkg::ROOT_MIN)
        else $error("overflow without a saturated root");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");
endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_root.valid),
    .i_out_ready (o_root.ready),
    .i_kind      (o_root.solution_kind),
    .i_rp        (o_root.root_plus),
    .i_rm        (o_root.root_minus),
    .i_ovf       (o_root.overflow)
);
`default_nettype wire
